FILE: rtl/assert_macros.svh
// Assertion helpers, clocked on i_clk and disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define DCG_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define DCG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define DCG_ASSERT_IMP(lbl, ante, cons, msg)

`define DCG_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: rtl/dcg_pkg.sv
package dcg_pkg;

    localparam int NOTE_W     = 7;
    localparam int KEY_W      = 4;
    localparam int SCALE_W    = 3;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;
    localparam int PC_W       = 4;
    localparam int OCT_N      = 12;
    localparam int MAX_NOTES  = 5;
    localparam int CNT_W      = 3;
    localparam int NDEG       = 4;
    localparam int OFF_W      = 6;

    localparam logic [NOTE_W-1:0] NOTE_MAX = 7'd127;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROOT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_TYPE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHORD_MODE = 2'd2;

    localparam logic [MODE_W-1:0] MODE_SINGLE  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_TRIAD   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SEVENTH = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NINTH   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SUS4    = 3'd4;
    localparam logic [MODE_W-1:0] MODE_POWER   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_OCTAVE  = 3'd6;
    localparam logic [MODE_W-1:0] MODE_ROOT    = 3'd7;

    localparam logic [PC_W-1:0] SCALE_LEN [8] = '{
        4'd12, 4'd7, 4'd7, 4'd7, 4'd7, 4'd5, 4'd5, 4'd7
    };

    localparam logic [PC_W-1:0] SCALE_INT [8][OCT_N] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
    };

    // bit j set when interval j (semitones above the tonic) is in the scale
    localparam logic [OCT_N-1:0] SCALE_MASK [8] = '{
        12'hFFF, 12'hAB5, 12'h5AD, 12'h6AD, 12'h6B5, 12'h295, 12'h4A9, 12'h9AD
    };

    localparam logic [PC_W-1:0] MODE_DEG [8][NDEG] = '{
        '{4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd2, 4'd4, 4'd0, 4'd0},
        '{4'd2, 4'd4, 4'd6, 4'd0},
        '{4'd2, 4'd4, 4'd6, 4'd8},
        '{4'd3, 4'd4, 4'd0, 4'd0},
        '{4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd0, 4'd0, 4'd0}
    };

    localparam logic [CNT_W-1:0] MODE_CNT [8] = '{
        3'd1, 3'd3, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd1
    };

    typedef struct packed {
        logic [MAX_NOTES-1:0][NOTE_W-1:0] notes;
        logic [CNT_W-1:0]                 count;
    } t_chord;

endpackage

FILE: rtl/diatonic_chord_generator.sv
// Diatonic chord generator.
// Input channel: i_valid / o_stall with i_root_note. A note request is taken
// at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall with o_chord_note and o_is_last. A chord
// leaves as 1 to 5 requests, root first; o_is_last marks the final note.
// Configuration: i_cfg_wen writes i_cfg_data to register i_cfg_index
// (0 key_root, 1 scale_type, 2 chord_mode); write only while no chord is
// in flight.
// The pipeline has six register stages: note split, scale search, snap select,
// rank and top note, degree offsets, then the output shift register, whose
// head is the offered note. The output shift register sends one note a
// cycle while i_stall is low, as many notes as the chord mode gives (1 to
// 5), and takes the next chord as the last note leaves. Pipeline stages
// keep filling while the output is busy.
// Reset (synchronous, i_rst_n low) clears the configuration registers to 0
// and empties the pipeline. While i_stall is high the offered note holds;
// stages behind it fill up and o_stall rises once all five are occupied.
`include "assert_macros.svh"

module diatonic_chord_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [dcg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dcg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [dcg_pkg::NOTE_W-1:0]      i_root_note,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [dcg_pkg::NOTE_W-1:0]      o_chord_note,
    output logic                            o_is_last
);

    localparam int NW  = dcg_pkg::NOTE_W;
    localparam int PW  = dcg_pkg::PC_W;
    localparam int ND  = dcg_pkg::NDEG;
    localparam int OW  = dcg_pkg::OFF_W;
    localparam int ON  = dcg_pkg::OCT_N;

    function automatic logic [PW-1:0] sub12(logic [PW-1:0] a, logic [PW-1:0] b);
        logic [PW:0] s;
        s = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + (PW+1)'(ON) - {1'b0, b});
        return s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] add12(logic [PW-1:0] a, logic [PW-1:0] b);
        logic [PW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PW+1)'(ON)) begin
            s = s - (PW+1)'(ON);
        end
        return s[PW-1:0];
    endfunction

    // configuration
    logic [dcg_pkg::KEY_W-1:0]   r_key_root;
    logic [dcg_pkg::SCALE_W-1:0] r_scale_type;
    logic [dcg_pkg::MODE_W-1:0]  r_chord_mode;

    logic [PW-1:0] key;
    logic [ON-1:0] smask;
    logic [PW-1:0] slen;

    assign key   = (r_key_root >= PW'(ON)) ? r_key_root - PW'(ON) : r_key_root;
    assign smask = dcg_pkg::SCALE_MASK[r_scale_type];
    assign slen  = dcg_pkg::SCALE_LEN[r_scale_type];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_root   <= '0;
            r_scale_type <= '0;
            r_chord_mode <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_index)
                dcg_pkg::CFG_KEY_ROOT:   r_key_root   <= i_cfg_data;
                dcg_pkg::CFG_SCALE_TYPE: r_scale_type <= i_cfg_data[dcg_pkg::SCALE_W-1:0];
                dcg_pkg::CFG_CHORD_MODE: r_chord_mode <= i_cfg_data[dcg_pkg::MODE_W-1:0];
                default: ;
            endcase
        end
    end

    // stage valids and enables
    logic r1_v, r2_v, r3_v, r4_v, r5_v;
    logic en1, en2, en3, en4, en5;
    logic ser_ready;

    assign en5     = !r5_v || ser_ready;
    assign en4     = !r4_v || en5;
    assign en3     = !r3_v || en4;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_stall = !en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (en4) r4_v <= r3_v;
            if (en5) r5_v <= r4_v;
        end
    end

    // stage 1: pitch class, floor(n/12) = (n*43) >> 9 for n < 128
    logic [NW-1:0]  r1_note;
    logic [PW-1:0]  r1_pc;
    logic [12:0]    n_prod;
    logic [3:0]     n_oct;
    logic [NW-1:0]  n_octx12;
    logic [NW-1:0]  n_pcw;

    assign n_prod   = 13'(i_root_note) * 13'd43;
    assign n_oct    = n_prod[12:9];
    assign n_octx12 = NW'({n_oct, 3'b000}) + NW'({n_oct, 2'b00});
    assign n_pcw    = i_root_note - n_octx12;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_note <= i_root_note;
            r1_pc   <= n_pcw[PW-1:0];
        end
    end

    // stage 2: nearest scale note below and above
    logic [NW-1:0] r2_note;
    logic [PW-1:0] r2_dlo, r2_dhi, r2_rel_lo, r2_rel_hi;
    logic          r2_lo_ok, r2_hi_ok;
    logic [PW-1:0] n_rel, n_dlo, n_dhi, n_rel_lo, n_rel_hi;
    logic          n_lo_ok, n_hi_ok;

    always_comb begin
        n_rel    = sub12(r1_pc, key);
        n_dlo    = '0;
        n_dhi    = '0;
        n_rel_lo = '0;
        n_rel_hi = '0;
        n_lo_ok  = 1'b0;
        n_hi_ok  = 1'b0;
        for (int d = ON - 1; d >= 0; d--) begin
            if (smask[sub12(n_rel, PW'(d))] && (r1_note >= NW'(d))) begin
                n_lo_ok  = 1'b1;
                n_dlo    = PW'(d);
                n_rel_lo = sub12(n_rel, PW'(d));
            end
            if (smask[add12(n_rel, PW'(d))]
                && (({1'b0, r1_note} + (NW+1)'(d)) <= {1'b0, dcg_pkg::NOTE_MAX})) begin
                n_hi_ok  = 1'b1;
                n_dhi    = PW'(d);
                n_rel_hi = add12(n_rel, PW'(d));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_note   <= r1_note;
            r2_dlo    <= n_dlo;
            r2_dhi    <= n_dhi;
            r2_rel_lo <= n_rel_lo;
            r2_rel_hi <= n_rel_hi;
            r2_lo_ok  <= n_lo_ok;
            r2_hi_ok  <= n_hi_ok;
        end
    end

    // stage 3: snap (single mode passes the note through); on a tie the smaller interval wins, then the lower note
    logic [NW-1:0] r3_root;
    logic [PW-1:0] r3_root_rel;
    logic          n_take_lo;
    logic [NW-1:0] n_root;

    assign n_take_lo = !r2_hi_ok || (r2_lo_ok && ((r2_dlo < r2_dhi)
                       || ((r2_dlo == r2_dhi) && (r2_rel_lo <= r2_rel_hi))));
    assign n_root    = (r_chord_mode == dcg_pkg::MODE_SINGLE) ? r2_note :
                       n_take_lo ? r2_note - NW'(r2_dlo) : r2_note + NW'(r2_dhi);

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_root     <= n_root;
            r3_root_rel <= n_take_lo ? r2_rel_lo : r2_rel_hi;
        end
    end

    // stage 4: degree rank of the root, highest scale note in range
    logic [NW-1:0] r4_root, r4_top;
    logic [PW-1:0] r4_root_rel, r4_rank;
    logic [ON-1:0] n_below;
    logic [PW-1:0] n_rel_top, n_dtop;

    always_comb begin
        for (int j = 0; j < ON; j++) begin
            n_below[j] = (PW'(j) < r3_root_rel);
        end
        n_rel_top = sub12(PW'(dcg_pkg::NOTE_MAX % ON), key);
        n_dtop    = '0;
        for (int d = ON - 1; d >= 0; d--) begin
            if (smask[sub12(n_rel_top, PW'(d))]) begin
                n_dtop = PW'(d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_root     <= r3_root;
            r4_root_rel <= r3_root_rel;
            r4_rank     <= PW'($countones(smask & n_below));
            r4_top      <= dcg_pkg::NOTE_MAX - NW'(n_dtop);
        end
    end

    // stage 5: semitone offsets of the added degrees
    logic [NW-1:0]         r5_root, r5_top;
    logic [ND-1:0][OW-1:0] r5_off;
    logic [ND-1:0][OW-1:0] n_off;

    always_comb begin
        logic [PW:0]   s;
        logic [1:0]    c;
        logic [PW-1:0] iv;
        logic [OW-1:0] oct_add;
        for (int j = 0; j < ND; j++) begin
            s = {1'b0, r4_rank} + {1'b0, dcg_pkg::MODE_DEG[r_chord_mode][j]};
            c = 2'd0;
            if (s >= {1'b0, slen}) begin
                s = s - {1'b0, slen};
                c = 2'd1;
            end
            if (s >= {1'b0, slen}) begin
                s = s - {1'b0, slen};
                c = 2'd2;
            end
            iv      = dcg_pkg::SCALE_INT[r_scale_type][s[PW-1:0]];
            oct_add = (c == 2'd2) ? OW'(2 * ON) : (c == 2'd1) ? OW'(ON) : '0;
            n_off[j] = OW'(iv) + oct_add - OW'(r4_root_rel);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_root <= r4_root;
            r5_top  <= r4_top;
            r5_off  <= n_off;
        end
    end

    // chord assembly into the output shift register
    dcg_pkg::t_chord n_chord;

    always_comb begin
        logic [NW:0]   sum;
        logic [NW:0]   p7;
        logic [NW:0]   p12;
        logic [ND-1:0][NW-1:0] dn;
        for (int j = 0; j < ND; j++) begin
            sum   = {1'b0, r5_root} + (NW+1)'(r5_off[j]);
            dn[j] = (sum > {1'b0, dcg_pkg::NOTE_MAX}) ? r5_top : sum[NW-1:0];
        end
        p7  = {1'b0, r5_root} + (NW+1)'(7);
        p12 = {1'b0, r5_root} + (NW+1)'(ON);
        n_chord.notes    = '0;
        n_chord.notes[0] = r5_root;
        n_chord.count    = dcg_pkg::MODE_CNT[r_chord_mode];
        case (r_chord_mode)
            dcg_pkg::MODE_TRIAD, dcg_pkg::MODE_SEVENTH,
            dcg_pkg::MODE_NINTH, dcg_pkg::MODE_SUS4: begin
                for (int j = 0; j < ND; j++) begin
                    n_chord.notes[j+1] = dn[j];
                end
            end
            dcg_pkg::MODE_POWER: begin
                n_chord.notes[1] = p7[NW] ? dcg_pkg::NOTE_MAX : p7[NW-1:0];
                n_chord.notes[2] = (p12 > {1'b0, dcg_pkg::NOTE_MAX}) ? dcg_pkg::NOTE_MAX
                                                                     : p12[NW-1:0];
            end
            dcg_pkg::MODE_OCTAVE: begin
                n_chord.notes[1] = (p12 > {1'b0, dcg_pkg::NOTE_MAX}) ? dcg_pkg::NOTE_MAX
                                                                     : p12[NW-1:0];
            end
            default: ;
        endcase
    end

    dcg_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (r5_v),
        .i_chord      (n_chord),
        .o_ready      (ser_ready),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_chord_note (o_chord_note),
        .o_is_last    (o_is_last)
    );

    `DCG_ASSERT_IMP(a_root_in_scale, r4_v && (r_chord_mode != dcg_pkg::MODE_SINGLE),
        smask[r4_root_rel] && (r4_rank < slen), "snapped root not on the scale")
    `DCG_ASSERT_IMP(a_top_range, r4_v, r4_top >= (dcg_pkg::NOTE_MAX - NW'(ON - 1)),
        "top scale note out of range")
    `DCG_ASSERT_NEXT(a_s5_hold, r5_v && !en5, r5_v && $stable(r5_root) && $stable(r5_off),
        "stalled stage lost its request")

endmodule

FILE: rtl/dcg_serializer.sv
`include "assert_macros.svh"

module dcg_serializer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  dcg_pkg::t_chord             i_chord,
    output logic                        o_ready,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [dcg_pkg::NOTE_W-1:0]  o_chord_note,
    output logic                        o_is_last
);

    logic [dcg_pkg::MAX_NOTES-1:0][dcg_pkg::NOTE_W-1:0] r_notes;
    logic [dcg_pkg::CNT_W-1:0]                          r_left;
    logic                                               take;
    logic                                               load;

    assign o_valid      = (r_left != '0);
    assign o_is_last    = (r_left == dcg_pkg::CNT_W'(1));
    assign o_chord_note = r_notes[0];
    assign take         = o_valid && !i_stall;
    assign o_ready      = !o_valid || (take && o_is_last);
    assign load         = i_load && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (load) begin
            r_left <= i_chord.count;
        end else if (take) begin
            r_left <= r_left - dcg_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_notes <= i_chord.notes;
        end else if (take) begin
            r_notes <= {dcg_pkg::NOTE_W'(0), r_notes[dcg_pkg::MAX_NOTES-1:1]};
        end
    end

    `DCG_ASSERT_IMP(a_load_count, load, (i_chord.count != '0) && (i_chord.count <= dcg_pkg::CNT_W'(dcg_pkg::MAX_NOTES)), "chord count out of range")
    `DCG_ASSERT_IMP(a_load_free, load, (r_left == '0) || (take && (r_left == dcg_pkg::CNT_W'(1))), "chord loaded over a pending one")
    `DCG_ASSERT_NEXT(a_drain_idle, take && o_is_last && !load, !o_valid, "request shown after last note")

endmodule
